FILE: hdl/quorum_commit_index_macros.svh
// ============================================================================
// Quorum commit index: assertion macros
// Shared helpers for the concurrent checks at the end of the top level.
// ============================================================================
`ifndef QUORUM_COMMIT_INDEX_MACROS_SVH
`define QUORUM_COMMIT_INDEX_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define QCI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define QCI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/qci_pkg.sv
// ============================================================================
// Quorum commit index package
// Shared constants, controller states and control structures.
// ============================================================================
package qci_pkg;

    // Default upper bound on the number of voters in one round.
    localparam int MAX_VOTERS_DEF = 16;
    // Width of the voter count register.
    localparam int VC_W           = 5;
    // Width of a log index.
    localparam int IDX_W          = 64;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_PLACE,
        ST_READ,
        ST_LOAD
    } t_qci_state;

    // Memory strobes from the controller to the store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    // Controller status seen by the top level.
    typedef struct packed {
        logic idle;
        logic walking;
    } t_qci_status;

endpackage

FILE: hdl/quorum_commit_index.sv
// ============================================================================
// Quorum commit index
// Majority log index over one round of voter reports.
// ============================================================================
// Usage: write the voter count on the cfg channel while the block is idle;
// any write discards a round in progress, and counts above MAX_VOTERS are
// taken as MAX_VOTERS. Each slave word is one voter: tdata holds the match
// index, tuser the acked flag (clear means index zero). After the last voter
// of the round one master word carries the quorum index, the (n/2+1)-th
// largest value of the round. With a count of zero every input word yields
// an all-ones result in the next cycle.
// Timing: each word is inserted in sorted order by walking down the store,
// one entry per cycle. The first word of a round goes straight to entry
// zero; a later word walks past each stored voter that holds a larger value
// through the single write port; no new word is taken until it is placed.
// After the last word the selected entry is read, then loaded as output.
// Reset clears the count, the round and the output register; no clearing
// pass runs. A stalled receiver holds the result; further words of the next
// round are still taken until another result needs the output register.
// ============================================================================
`include "quorum_commit_index_macros.svh"

module quorum_commit_index #(
    parameter int MAX_VOTERS = qci_pkg::MAX_VOTERS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [qci_pkg::VC_W-1:0]  i_cfg_data,      // [4:0] voter_count
    // Voter reports
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    input  logic [qci_pkg::IDX_W-1:0] i_s_axis_tdata,  // [63:0] match_index
    input  logic                      i_s_axis_tuser,  // [0] acked
    // Commit results
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    output logic [qci_pkg::IDX_W-1:0] o_m_axis_tdata   // [63:0] committed_index
);

    localparam int AW = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1;
    localparam int CW = $clog2(MAX_VOTERS + 1);

    logic [CW-1:0]             r_n, n_n;
    logic [AW-1:0]             r_sel, n_sel;
    logic                      w_cfg_wr;
    qci_pkg::t_mem_ctl         w_mem;
    logic [AW-1:0]             w_wr_addr;
    logic [qci_pkg::IDX_W-1:0] w_wr_data;
    logic [AW-1:0]             w_rd_addr;
    logic [qci_pkg::IDX_W-1:0] w_rd_data;
    logic [CW-1:0]             w_count;
    qci_pkg::t_qci_status      w_status;
    logic                      w_zero_take;
    logic                      w_ones_out;
    logic                      w_ready_ok;

    // Configuration: saturate the count and precompute the selected rank.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_comb begin
        if (int'(i_cfg_data) > MAX_VOTERS) begin
            n_n = CW'(MAX_VOTERS);
        end else begin
            n_n = CW'(i_cfg_data);
        end
        n_sel = AW'(CW'(n_n - (n_n >> 1) - CW'(1)));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n   <= '0;
            r_sel <= '0;
        end else if (w_cfg_wr) begin
            r_n   <= n_n;
            r_sel <= n_sel;
        end
    end

    // Insertion controller.
    qci_ctrl #(
        .MAX_VOTERS (MAX_VOTERS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_cfg_wr),
        .i_n       (r_n),
        .i_sel     (r_sel),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_match   (i_s_axis_tdata),
        .i_acked   (i_s_axis_tuser),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata),
        .o_mem     (w_mem),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_count   (w_count),
        .o_status  (w_status)
    );

    // Sorted value store.
    qci_store #(
        .MAX_VOTERS (MAX_VOTERS),
        .AW         (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_ctl     (w_mem),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // Terms used by the checks below.
    assign w_zero_take = i_s_axis_tvalid && o_s_axis_tready && (r_n == '0);
    assign w_ones_out  = o_m_axis_tvalid && (o_m_axis_tdata == '1);
    assign w_ready_ok  = w_status.idle && !w_status.walking;

    // With no voters configured, a taken word gives an all-ones result next.
    `QCI_ASSERT_NEXT(a_zero_voters, i_clk, i_rst_n, w_zero_take, w_ones_out, "no all-ones result")

    // The round fill never passes the configured voter count.
    `QCI_ASSERT_IMP(a_count_range, i_clk, i_rst_n, r_n != '0, w_count <= r_n, "fill too high")

    // New words are taken only while the controller is idle.
    `QCI_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_s_axis_tready, w_ready_ok, "ready outside idle")

endmodule

FILE: hdl/qci_store.sv
// ============================================================================
// Quorum commit index value store
// Single-port-write, single-port-read memory with a registered read.
// ============================================================================
module qci_store #(
    parameter int MAX_VOTERS = qci_pkg::MAX_VOTERS_DEF,
    parameter int AW         = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1
) (
    input  logic                     i_clk,
    input  qci_pkg::t_mem_ctl        i_ctl,
    input  logic [AW-1:0]            i_wr_addr,
    input  logic [qci_pkg::IDX_W-1:0] i_wr_data,
    input  logic [AW-1:0]            i_rd_addr,
    output logic [qci_pkg::IDX_W-1:0] o_rd_data
);

    logic [qci_pkg::IDX_W-1:0] r_mem [MAX_VOTERS];
    logic [qci_pkg::IDX_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/qci_ctrl.sv
// ============================================================================
// Quorum commit index controller
// Sorted insertion walk over the store and the result output register.
// ============================================================================
module qci_ctrl #(
    parameter int MAX_VOTERS = qci_pkg::MAX_VOTERS_DEF,
    parameter int AW         = (MAX_VOTERS > 1) ? $clog2(MAX_VOTERS) : 1,
    parameter int CW         = $clog2(MAX_VOTERS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Round setup from the configuration register
    input  logic                      i_clear,
    input  logic [CW-1:0]             i_n,
    input  logic [AW-1:0]             i_sel,
    // Input words
    input  logic                      i_s_valid,
    output logic                      o_s_ready,
    input  logic [qci_pkg::IDX_W-1:0] i_match,
    input  logic                      i_acked,
    // Result words
    output logic                      o_m_valid,
    input  logic                      i_m_ready,
    output logic [qci_pkg::IDX_W-1:0] o_m_data,
    // Store access
    output qci_pkg::t_mem_ctl         o_mem,
    output logic [AW-1:0]             o_wr_addr,
    output logic [qci_pkg::IDX_W-1:0] o_wr_data,
    output logic [AW-1:0]             o_rd_addr,
    input  logic [qci_pkg::IDX_W-1:0] i_rd_data,
    // Status
    output logic [CW-1:0]             o_count,
    output qci_pkg::t_qci_status      o_status
);

    qci_pkg::t_qci_state       r_state, n_state;
    logic [CW-1:0]             r_count;
    logic [AW-1:0]             r_pos;
    logic [qci_pkg::IDX_W-1:0] r_val;
    logic                      r_out_valid;
    logic [qci_pkg::IDX_W-1:0] r_out_data;

    logic                      w_out_free;
    logic                      w_take;
    logic                      w_none;
    logic                      w_last;
    logic                      w_gt;
    logic [qci_pkg::IDX_W-1:0] w_in_val;
    logic                      w_done;
    logic                      w_load_mem;
    logic                      w_load_ones;

    // Handshake and compare terms.
    assign w_out_free = !r_out_valid || i_m_ready;
    assign w_none     = (i_n == '0);
    assign o_s_ready  = (r_state == qci_pkg::ST_IDLE) && (!w_none || w_out_free);
    assign w_take     = i_s_valid && o_s_ready;
    assign w_in_val   = i_acked ? i_match : '0;
    assign w_last     = (CW'(r_count + 1'b1) == i_n);
    assign w_gt       = (i_rd_data > r_val);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            qci_pkg::ST_IDLE: begin
                if (w_take && !w_none) begin
                    if (r_count == '0) begin
                        n_state = w_last ? qci_pkg::ST_READ : qci_pkg::ST_IDLE;
                    end else begin
                        n_state = qci_pkg::ST_WALK;
                    end
                end
            end
            qci_pkg::ST_WALK: begin
                if (w_gt) begin
                    n_state = (r_pos == AW'(1)) ? qci_pkg::ST_PLACE : qci_pkg::ST_WALK;
                end else begin
                    n_state = w_last ? qci_pkg::ST_READ : qci_pkg::ST_IDLE;
                end
            end
            qci_pkg::ST_PLACE: n_state = w_last ? qci_pkg::ST_READ : qci_pkg::ST_IDLE;
            qci_pkg::ST_READ:  n_state = qci_pkg::ST_LOAD;
            qci_pkg::ST_LOAD: begin
                if (w_out_free) begin
                    n_state = qci_pkg::ST_IDLE;
                end
            end
            default: n_state = qci_pkg::ST_IDLE;
        endcase
    end

    // Store strobes and per-state actions.
    always_comb begin
        o_mem       = '0;
        o_wr_addr   = '0;
        o_wr_data   = r_val;
        o_rd_addr   = '0;
        w_done      = 1'b0;
        w_load_mem  = 1'b0;
        w_load_ones = 1'b0;
        case (r_state)
            qci_pkg::ST_IDLE: begin
                if (w_take && w_none) begin
                    w_load_ones = 1'b1;
                end else if (w_take) begin
                    if (r_count == '0) begin
                        // First value of the round goes straight to entry zero.
                        o_mem.wr_en = 1'b1;
                        o_wr_data   = w_in_val;
                        w_done      = 1'b1;
                    end else begin
                        o_mem.rd_en = 1'b1;
                        o_rd_addr   = AW'(r_count - 1'b1);
                    end
                end
            end
            qci_pkg::ST_WALK: begin
                o_mem.wr_en = 1'b1;
                o_wr_addr   = r_pos;
                if (w_gt) begin
                    // Shift the larger entry up and look one place lower.
                    o_wr_data = i_rd_data;
                    if (r_pos != AW'(1)) begin
                        o_mem.rd_en = 1'b1;
                        o_rd_addr   = AW'(r_pos - AW'(2));
                    end
                end else begin
                    w_done = 1'b1;
                end
            end
            qci_pkg::ST_PLACE: begin
                o_mem.wr_en = 1'b1;
                w_done      = 1'b1;
            end
            qci_pkg::ST_READ: begin
                o_mem.rd_en = 1'b1;
                o_rd_addr   = i_sel;
            end
            qci_pkg::ST_LOAD: w_load_mem = w_out_free;
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qci_pkg::ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (i_clear || w_load_mem) begin
                r_count <= '0;
            end else if (w_done) begin
                r_count <= CW'(r_count + 1'b1);
            end
        end
    end

    // Walk payload: value being inserted and its current slot.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_val <= w_in_val;
            r_pos <= AW'(r_count);
        end else if ((r_state == qci_pkg::ST_WALK) && w_gt) begin
            r_pos <= AW'(r_pos - 1'b1);
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_mem || w_load_ones) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_ones) begin
            r_out_data <= '1;
        end else if (w_load_mem) begin
            r_out_data <= i_rd_data;
        end
    end

    assign o_m_valid        = r_out_valid;
    assign o_m_data         = r_out_data;
    assign o_count          = r_count;
    assign o_status.idle    = (r_state == qci_pkg::ST_IDLE);
    assign o_status.walking = (r_state == qci_pkg::ST_WALK);

endmodule
